// ===== design/lpht_pkg.sv =====
// shared types and constants of the linear probing hash table
package lpht_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned DIV_W    = 5;

  localparam logic [CNT_W-1:0] BUCKET_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK        = 2'd0,
    RES_MISSING   = 2'd1,
    RES_DUPLICATE = 2'd2,
    RES_FULL      = 2'd3
  } res_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_DELETED = 2'd2,
    SLOT_BAD     = 2'd3
  } slot_st_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

endpackage

// ===== design/lpht_req_if.sv =====
// command channel of the hash table: valid, ready and the command beat
interface lpht_req_if;
  import lpht_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [KEY_W-1:0]        key;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, command, key, value, input ready);
  modport sink (input valid, command, key, value, output ready);
endinterface

// ===== design/lpht_rsp_if.sv =====
// result channel of the hash table: valid, ready and the result beat
interface lpht_rsp_if;
  import lpht_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] found_value;
  logic [SLOT_W-1:0]       slot;

  modport source (output valid, status, found_value, slot, input ready);
  modport sink (input valid, status, found_value, slot, output ready);
endinterface

// ===== design/linear_probe_hash_table.sv =====
// open-addressing hash table with linear probing, memory based
// steps: accept, hash over the key bytes, bit-serial remainder by the bucket count,
//   then a read state and a check state per probed slot, then the result register
// one command at a time: no new command is taken until the result is registered
// the probe loop over the slot memories sets the worst case (every bucket probed)
// reset: a clearing pass marks every slot empty, no beat taken
module linear_probe_hash_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned KEY_BYTES   = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lpht_pkg::CNT_W-1:0] cfg_wdata_i,
  lpht_req_if.sink                   req,
  lpht_rsp_if.source                 rsp
);
  import lpht_pkg::*;

  localparam int unsigned IDX_W     = $clog2(TABLE_DEPTH);
  localparam int unsigned KW        = 8 * KEY_BYTES;
  localparam int unsigned CMP_W     = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int unsigned DEPTH_CAP = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;

  // slot memories
  logic [1:0]       st_mem  [TABLE_DEPTH];
  logic [KW-1:0]    key_mem [TABLE_DEPTH];
  logic [VAL_W-1:0] val_mem [TABLE_DEPTH];
  logic [1:0]       st_rdata_q;
  logic [KW-1:0]    key_rdata_q;
  logic [VAL_W-1:0] val_rdata_q;

  logic             st_we;
  logic [IDX_W-1:0] st_waddr;
  slot_st_e         st_wdata;
  logic             kv_we;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    bucket_q;
  logic [CNT_W-1:0]    n_eff;
  logic [IDX_W-1:0]    clr_q;
  logic [DIV_W-1:0]    div_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                free_vld_q;
  logic [IDX_W-1:0]    free_q;
  logic [IDX_W-1:0]    idx_q;
  cmd_e                cmd_q;
  logic [KW-1:0]       key_q;
  logic [KW-1:0]       key_sh_q;
  logic [HASH_W-1:0]   hash_q;
  logic [CNT_W-1:0]    rem_q;
  logic [VAL_W-1:0]    val_q;
  res_e                res_status_q, res_status_d;
  logic [VAL_W-1:0]    res_value_q, res_value_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [VAL_W-1:0]    out_value_q;
  logic [SLOT_W-1:0]   out_slot_q;

  logic [KW-1:0]    key_norm;
  logic             alive;
  logic             accept;
  logic             out_free;
  logic [7:0]       hbyte;
  logic [CNT_W:0]   rem_t;
  logic [CNT_W:0]   rem_nx;
  logic [CMP_W-1:0] idx_inc;
  logic [IDX_W-1:0] idx_nx;
  logic             is_used;
  logic             is_empty;
  logic             match;
  logic             last;
  logic             end_probe;
  logic             take_here;
  logic             ins_ok;
  logic [IDX_W-1:0] ins_slot;

  // key normalization and effective bucket count
  always_comb begin
    alive    = 1'b1;
    key_norm = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (req.key[8*i +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        key_norm[8*i +: 8] = req.key[8*i +: 8];
      end
    end
  end

  always_comb begin
    if (bucket_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (bucket_q > CNT_W'(DEPTH_CAP)) begin
      n_eff = CNT_W'(DEPTH_CAP);
    end else begin
      n_eff = bucket_q;
    end
  end

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid_q || rsp.ready;
  assign req.ready = (state_q == S_IDLE);

  // datapath helpers
  assign hbyte  = key_sh_q[7:0];
  assign rem_t  = {rem_q, hash_q[HASH_W-1]};
  assign rem_nx = (rem_t >= {1'b0, n_eff}) ? (rem_t - {1'b0, n_eff}) : rem_t;

  assign idx_inc = CMP_W'(idx_q) + CMP_W'(1);
  assign idx_nx  = (idx_inc == CMP_W'(n_eff)) ? '0 : IDX_W'(idx_inc);

  assign is_used   = (st_rdata_q == SLOT_USED);
  assign is_empty  = (st_rdata_q == SLOT_EMPTY);
  assign match     = is_used && (key_rdata_q == key_q);
  assign last      = ({1'b0, cnt_q} + 1'b1) == {1'b0, n_eff};
  assign end_probe = match || is_empty || last;
  assign take_here = !is_used && !free_vld_q;
  assign ins_ok    = free_vld_q || !is_used;
  assign ins_slot  = free_vld_q ? free_q : idx_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == IDX_W'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = (cmd_e'(req.command) == CMD_UNUSED) ? S_DONE : S_HASH;
        end
      end
      S_HASH: begin
        if (hbyte == 8'd0) begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (div_q == DIV_W'(HASH_W - 1)) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_CHECK;
      S_CHECK: state_d = end_probe ? S_DONE : S_READ;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory writes and result of the probe
  always_comb begin
    st_we        = 1'b0;
    st_waddr     = idx_q;
    st_wdata     = SLOT_USED;
    kv_we        = 1'b0;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_slot_d   = res_slot_q;
    unique case (state_q)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_q;
        st_wdata = SLOT_EMPTY;
      end
      S_IDLE: begin
        res_status_d = RES_MISSING;
        res_value_d  = '0;
        res_slot_d   = '0;
      end
      S_CHECK: begin
        if (end_probe) begin
          unique case (cmd_q)
            CMD_INSERT: begin
              if (match) begin
                res_status_d = RES_DUPLICATE;
              end else if (ins_ok) begin
                st_we        = 1'b1;
                st_waddr     = ins_slot;
                st_wdata     = SLOT_USED;
                kv_we        = 1'b1;
                res_status_d = RES_OK;
                res_slot_d   = SLOT_W'(ins_slot);
              end else begin
                res_status_d = RES_FULL;
              end
            end
            CMD_SEARCH: begin
              if (match) begin
                res_status_d = RES_OK;
                res_value_d  = val_rdata_q;
                res_slot_d   = SLOT_W'(idx_q);
              end
            end
            CMD_DELETE: begin
              if (match) begin
                st_we        = 1'b1;
                st_waddr     = idx_q;
                st_wdata     = SLOT_DELETED;
                res_status_d = RES_OK;
                res_slot_d   = SLOT_W'(idx_q);
              end
            end
            default: res_status_d = RES_MISSING;
          endcase
        end
      end
      default: res_status_d = res_status_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (kv_we) begin
      key_mem[st_waddr] <= key_q;
      val_mem[st_waddr] <= val_q;
    end
    st_rdata_q  <= st_mem[idx_q];
    key_rdata_q <= key_mem[idx_q];
    val_rdata_q <= val_mem[idx_q];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      bucket_q    <= BUCKET_RESET;
      clr_q       <= '0;
      div_q       <= '0;
      cnt_q       <= '0;
      free_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        bucket_q <= cfg_wdata_i;
      end
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == S_HASH) begin
        div_q <= '0;
      end else if (state_q == S_MOD) begin
        div_q <= div_q + 1'b1;
      end
      if (accept) begin
        cnt_q      <= '0;
        free_vld_q <= 1'b0;
      end else if (state_q == S_CHECK && !end_probe) begin
        cnt_q <= cnt_q + 1'b1;
        if (take_here) begin
          free_vld_q <= 1'b1;
        end
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_slot_q   <= res_slot_d;
    if (accept) begin
      cmd_q    <= cmd_e'(req.command);
      key_q    <= key_norm;
      key_sh_q <= key_norm;
      val_q    <= req.value;
      hash_q   <= '0;
      rem_q    <= '0;
    end
    if (state_q == S_HASH && hbyte != 8'd0) begin
      hash_q   <= (hash_q << 5) - hash_q + HASH_W'(hbyte);
      key_sh_q <= key_sh_q >> 8;
    end
    if (state_q == S_MOD) begin
      hash_q <= hash_q << 1;
      rem_q  <= rem_nx[CNT_W-1:0];
      if (div_q == DIV_W'(HASH_W - 1)) begin
        idx_q <= IDX_W'(rem_nx[CNT_W-1:0]);
      end
    end
    if (state_q == S_CHECK && !end_probe) begin
      idx_q <= idx_nx;
      if (take_here) begin
        free_q <= idx_q;
      end
    end
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.status      = out_status_q;
  assign rsp.found_value = out_value_q;
  assign rsp.slot        = out_slot_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted command left the block idle");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> CMP_W'(idx_q) < CMP_W'(n_eff))
    else $error("probe index beyond bucket count");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> cnt_q < n_eff)
    else $error("probe count beyond bucket count");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> (state_q == S_CHECK || state_q == S_CLEAR))
    else $error("slot memory written outside probe or clear");

endmodule
